// ===== rtl/ftpb_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register codes, reset values and divider handshake types for the trail buffer.
package ftpb_pkg;

    localparam int POS_W      = 32;
    localparam int AGE_W      = 24;
    localparam int Q_W        = 16;
    localparam int COLOR_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int WIDTH_W    = 16;
    localparam int MAXP_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // divider retires this many quotient bits per cycle
    localparam int DIV_BITS   = 2;
    localparam int DIV_ITER   = Q_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_ITER);

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ADD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_END   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_START = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_END   = 3'd6;

    // configuration reset values
    localparam logic               RST_AUTO_ADD    = 1'b1;
    localparam logic [MAXP_W-1:0]  RST_MAX_POINTS  = 7'd64;
    localparam logic [AGE_W-1:0]   RST_LIFETIME    = 24'd1000000;
    localparam logic [COLOR_W-1:0] RST_COLOR_START = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] RST_COLOR_END   = 32'h0000_0000;
    localparam logic [WIDTH_W-1:0] RST_WIDTH_START = 16'd256;
    localparam logic [WIDTH_W-1:0] RST_WIDTH_END   = 16'd0;

    typedef struct packed {
        logic             start;
        logic [AGE_W-1:0] num;
        logic [AGE_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quo;
    } t_div_rsp;

endpackage

// ===== rtl/ftpb_div.sv =====
`timescale 1ns / 1ps
// Radix-4 restoring divider: floor(num * 2^16 / den) for num < den.
module ftpb_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ftpb_pkg::t_div_req  i_req,
    output ftpb_pkg::t_div_rsp  o_rsp
);

    localparam int AW = ftpb_pkg::AGE_W;
    localparam int QW = ftpb_pkg::Q_W;
    localparam int CW = ftpb_pkg::DIV_CNT_W;

    logic [AW:0]   r_rem;
    logic [AW-1:0] r_den;
    logic [QW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [AW:0]   n_rem;
    logic [QW-1:0] n_quo;

    // remainder stays below den, so a shifted value fits AW+1 bits
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < ftpb_pkg::DIV_BITS; k++) begin
            n_rem = {n_rem[AW-1:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem = n_rem - {1'b0, r_den};
                n_quo = {n_quo[QW-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ftpb_pkg::DIV_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== rtl/fading_trail_point_buffer_core.sv =====
`timescale 1ns / 1ps
// Top level of the fading trail point buffer: ring storage, aging pass and color/width blend.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one transaction is one frame, a position
//    (signed Q16.16) plus the elapsed time in microseconds.
//  - Output channel (o_out_valid / i_out_stall): each frame yields one transaction per
//    surviving point, oldest first, o_last set on the newest. With no survivors a single
//    transaction with o_point_valid 0 and o_last 1 is sent.
//  - Config port: i_cfg_we writes i_cfg_data into register i_cfg_index; write only while idle.
//  - Steps: a frame is accepted in S_IDLE; each expired point is read and its age updated,
//    each live point goes through memory read, age update, the radix-4 divider that
//    forms age/lifetime, one blend multiply step and one output load step.
//    The divider takes most of the time spent on each live point.
//  - Points live in two single-port memories (position, age) of CAPACITY entries; the
//    pass walks them oldest to newest with read-modify-write of the age.
//  - o_in_stall is high while a frame is being worked on.
//  - Receiver stall: the result sits in the output register; the pass waits only when the
//    next result is ready and the register is still full. A new frame can be taken while
//    the last result of the previous one waits.
//  - Reset (synchronous, active low) empties the trail and restores register defaults;
//    memory contents are not cleared, only live entries are ever read.
module fading_trail_point_buffer_core #(
    parameter int CAPACITY = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // frame input
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [ftpb_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [ftpb_pkg::POS_W-1:0]      i_pos_y,
    input  logic signed [ftpb_pkg::POS_W-1:0]      i_pos_z,
    input  logic        [ftpb_pkg::AGE_W-1:0]      i_elapsed,
    // point output
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_point_valid,
    output logic signed [ftpb_pkg::POS_W-1:0]      o_out_x,
    output logic signed [ftpb_pkg::POS_W-1:0]      o_out_y,
    output logic signed [ftpb_pkg::POS_W-1:0]      o_out_z,
    output logic        [ftpb_pkg::CHAN_W-1:0]     o_red,
    output logic        [ftpb_pkg::CHAN_W-1:0]     o_green,
    output logic        [ftpb_pkg::CHAN_W-1:0]     o_blue,
    output logic        [ftpb_pkg::CHAN_W-1:0]     o_alpha,
    output logic        [ftpb_pkg::WIDTH_W-1:0]    o_point_width,
    output logic                                   o_last,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic        [ftpb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [ftpb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    localparam int PW  = ftpb_pkg::POS_W;
    localparam int AW  = ftpb_pkg::AGE_W;
    localparam int QW  = ftpb_pkg::Q_W;
    localparam int CHW = ftpb_pkg::CHAN_W;
    localparam int WW  = ftpb_pkg::WIDTH_W;
    localparam int NCH = ftpb_pkg::NUM_CHAN;
    localparam int MPW = ftpb_pkg::MAXP_W;

    // blend product widths: signed diff times unsigned Q0.16 fraction
    localparam int CP_W = (CHW + 1) + (QW + 1);
    localparam int WP_W = (WW + 1) + (QW + 1);

    // pass sequencer
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_AGE   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_BLD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_EMPTY = 3'd6;

    function automatic logic [IDX_W-1:0] f_wrap(input logic [SUM_W-1:0] s);
        if (s >= CAP_S) begin
            return IDX_W'(s - CAP_S);
        end
        return IDX_W'(s);
    endfunction

    // configuration
    logic                r_auto_add;
    logic [MPW-1:0]      r_max_points;
    logic [AW-1:0]       r_lifetime;
    logic [31:0]         r_color_start;
    logic [31:0]         r_color_end;
    logic [WW-1:0]       r_width_start;
    logic [WW-1:0]       r_width_end;

    // trail control
    logic [2:0]          r_state;
    logic [IDX_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_scan;
    logic [CNT_W-1:0]    r_remain;
    logic [AW-1:0]       r_elapsed;
    logic                r_last;

    // storage
    logic [3*PW-1:0]     pos_mem [CAPACITY];
    logic [AW-1:0]       age_mem [CAPACITY];
    logic [3*PW-1:0]     r_pos_q;
    logic [AW-1:0]       r_age_q;

    // blend stage
    logic signed [CP_W-1:0] r_cprod [NCH];
    logic signed [WP_W-1:0] r_wprod;

    // output register
    logic                r_ov;
    logic                r_o_pv;
    logic [PW-1:0]       r_o_x;
    logic [PW-1:0]       r_o_y;
    logic [PW-1:0]       r_o_z;
    logic [CHW-1:0]      r_o_chan [NCH];
    logic [WW-1:0]       r_o_width;
    logic                r_o_last;

    ftpb_pkg::t_div_req  div_req;
    ftpb_pkg::t_div_rsp  div_rsp;

    // ------------------------------------------------------------------
    // Append (when auto_add is set): drop oldest if full, place at head+count, trim to max_points
    // ------------------------------------------------------------------
    logic                in_acc;
    logic                full;
    logic [IDX_W-1:0]    h1;
    logic [CNT_W-1:0]    c1;
    logic [CNT_W-1:0]    c2;
    logic [IDX_W-1:0]    wslot;
    logic [CNT_W-1:0]    limit;
    logic                trim;
    logic [IDX_W-1:0]    a_head;
    logic [CNT_W-1:0]    a_count;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        full  = (r_count >= CAP_C);
        h1    = full ? f_wrap(SUM_W'(r_head) + SUM_W'(1)) : r_head;
        c1    = full ? (r_count - 1'b1) : r_count;
        wslot = f_wrap(SUM_W'(h1) + SUM_W'(c1));
        c2    = c1 + 1'b1;
        limit = (r_max_points > MPW'(CAPACITY)) ? CAP_C : CNT_W'(r_max_points);
        trim  = (c2 > limit);
        if (!r_auto_add) begin
            a_head  = r_head;
            a_count = r_count;
        end else if (trim) begin
            a_head  = f_wrap(SUM_W'(h1) + SUM_W'(c2 - limit));
            a_count = limit;
        end else begin
            a_head  = h1;
            a_count = c2;
        end
    end

    // ------------------------------------------------------------------
    // Aging of the entry just read (saturating), expiry test
    // ------------------------------------------------------------------
    logic [AW:0]    age_sum;
    logic [AW-1:0]  new_age;
    logic           dead;

    assign age_sum = {1'b0, r_age_q} + {1'b0, r_elapsed};
    assign new_age = age_sum[AW] ? ftpb_pkg::AGE_MAX : age_sum[AW-1:0];
    assign dead    = (new_age >= r_lifetime);

    assign div_req.start = (r_state == S_AGE) && !dead;
    assign div_req.num   = new_age;
    assign div_req.den   = r_lifetime;

    ftpb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Blend: out = start + floor((end - start) * t / 2^16)
    // ------------------------------------------------------------------
    logic signed [QW:0]     t_s;
    logic signed [CHW:0]    cdiff [NCH];
    logic signed [CP_W-1:0] n_cprod [NCH];
    logic signed [WW:0]     wdiff;
    logic signed [WP_W-1:0] n_wprod;
    logic signed [CP_W-1:0] csum [NCH];
    logic signed [WP_W-1:0] wsum;

    always_comb begin
        t_s = $signed({1'b0, div_rsp.quo});
        for (int c = 0; c < NCH; c++) begin
            cdiff[c]   = $signed({1'b0, r_color_end[31-CHW*c -: CHW]})
                       - $signed({1'b0, r_color_start[31-CHW*c -: CHW]});
            n_cprod[c] = cdiff[c] * t_s;
            csum[c]    = $signed({{(CP_W-CHW){1'b0}}, r_color_start[31-CHW*c -: CHW]})
                       + (r_cprod[c] >>> QW);
        end
        wdiff   = $signed({1'b0, r_width_end}) - $signed({1'b0, r_width_start});
        n_wprod = wdiff * t_s;
        wsum    = $signed({{(WP_W-WW){1'b0}}, r_width_start}) + (r_wprod >>> QW);
    end

    // ------------------------------------------------------------------
    // Output register handshake
    // ------------------------------------------------------------------
    logic out_free;
    logic ld_pt;
    logic ld_empty;

    assign out_free = !r_ov || !i_out_stall;
    assign ld_pt    = (r_state == S_OUT) && out_free;
    assign ld_empty = (r_state == S_EMPTY) && out_free;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_add    <= ftpb_pkg::RST_AUTO_ADD;
            r_max_points  <= ftpb_pkg::RST_MAX_POINTS;
            r_lifetime    <= ftpb_pkg::RST_LIFETIME;
            r_color_start <= ftpb_pkg::RST_COLOR_START;
            r_color_end   <= ftpb_pkg::RST_COLOR_END;
            r_width_start <= ftpb_pkg::RST_WIDTH_START;
            r_width_end   <= ftpb_pkg::RST_WIDTH_END;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ftpb_pkg::CFG_AUTO_ADD:    r_auto_add    <= i_cfg_data[0];
                ftpb_pkg::CFG_MAX_POINTS:  r_max_points  <= i_cfg_data[MPW-1:0];
                ftpb_pkg::CFG_LIFETIME:    r_lifetime    <= i_cfg_data[AW-1:0];
                ftpb_pkg::CFG_COLOR_START: r_color_start <= i_cfg_data[31:0];
                ftpb_pkg::CFG_COLOR_END:   r_color_end   <= i_cfg_data[31:0];
                ftpb_pkg::CFG_WIDTH_START: r_width_start <= i_cfg_data[WW-1:0];
                ftpb_pkg::CFG_WIDTH_END:   r_width_end   <= i_cfg_data[WW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: one pass over the live entries per frame. Expired points
    // form a run from the oldest end, so they pop the head as they go.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_scan   <= '0;
            r_remain <= '0;
            r_last   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            // a load refills the register in the cycle it drains
            if (ld_pt || ld_empty) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_head   <= a_head;
                        r_count  <= a_count;
                        r_scan   <= a_head;
                        r_remain <= a_count;
                        r_state  <= (a_count == '0) ? S_EMPTY : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_AGE;
                end
                S_AGE: begin
                    r_scan   <= f_wrap(SUM_W'(r_scan) + SUM_W'(1));
                    r_remain <= r_remain - 1'b1;
                    if (dead) begin
                        r_head  <= f_wrap(SUM_W'(r_head) + SUM_W'(1));
                        r_count <= r_count - 1'b1;
                        if (r_remain == CNT_W'(1)) begin
                            r_state <= (r_count == CNT_W'(1)) ? S_EMPTY : S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else begin
                        r_last  <= (r_remain == CNT_W'(1));
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_BLD;
                    end
                end
                S_BLD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= (r_remain == '0) ? S_IDLE : S_RD;
                    end
                end
                S_EMPTY: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Memories: one write port each, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc && r_auto_add) begin
            pos_mem[wslot] <= {i_pos_x, i_pos_y, i_pos_z};
        end
        if (r_state == S_RD) begin
            r_pos_q <= pos_mem[r_scan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && r_auto_add) begin
            age_mem[wslot] <= '0;
        end else if (r_state == S_AGE) begin
            age_mem[r_scan] <= new_age;
        end
        if (r_state == S_RD) begin
            r_age_q <= age_mem[r_scan];
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_elapsed <= i_elapsed;
        end
        if (r_state == S_BLD) begin
            r_cprod <= n_cprod;
            r_wprod <= n_wprod;
        end
        if (ld_pt) begin
            r_o_pv    <= 1'b1;
            r_o_x     <= r_pos_q[3*PW-1:2*PW];
            r_o_y     <= r_pos_q[2*PW-1:PW];
            r_o_z     <= r_pos_q[PW-1:0];
            for (int c = 0; c < NCH; c++) begin
                r_o_chan[c] <= csum[c][CHW-1:0];
            end
            r_o_width <= wsum[WW-1:0];
            r_o_last  <= r_last;
        end else if (ld_empty) begin
            r_o_pv    <= 1'b0;
            r_o_x     <= '0;
            r_o_y     <= '0;
            r_o_z     <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_o_chan[c] <= '0;
            end
            r_o_width <= '0;
            r_o_last  <= 1'b1;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_point_valid = r_o_pv;
    assign o_out_x       = $signed(r_o_x);
    assign o_out_y       = $signed(r_o_y);
    assign o_out_z       = $signed(r_o_z);
    assign o_red         = r_o_chan[0];
    assign o_green       = r_o_chan[1];
    assign o_blue        = r_o_chan[2];
    assign o_alpha       = r_o_chan[3];
    assign o_point_width = r_o_width;
    assign o_last        = r_o_last;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fading_trail_point_buffer_core with a built-in trail predictor.
module tb_top;

    localparam int TRAIL_CAP  = 64;
    localparam int POS_W      = ftpb_pkg::POS_W;
    localparam int AGE_W      = ftpb_pkg::AGE_W;
    localparam int Q_W        = ftpb_pkg::Q_W;
    localparam int CHAN_W     = ftpb_pkg::CHAN_W;
    localparam int COLOR_W    = ftpb_pkg::COLOR_W;
    localparam int WIDTH_W    = ftpb_pkg::WIDTH_W;
    localparam int MAXP_W     = ftpb_pkg::MAXP_W;
    localparam int CFG_IDX_W  = ftpb_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ftpb_pkg::CFG_DATA_W;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [AGE_W-1:0]        elapsed;
    } t_frame;

    typedef struct packed {
        logic                    live;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [CHAN_W-1:0]       red;
        logic [CHAN_W-1:0]       green;
        logic [CHAN_W-1:0]       blue;
        logic [CHAN_W-1:0]       alpha;
        logic [WIDTH_W-1:0]      width;
        logic                    last;
    } t_point;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [POS_W-1:0] i_pos_x;
    logic signed [POS_W-1:0] i_pos_y;
    logic signed [POS_W-1:0] i_pos_z;
    logic [AGE_W-1:0]        i_elapsed;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_point_valid;
    logic signed [POS_W-1:0] o_out_x;
    logic signed [POS_W-1:0] o_out_y;
    logic signed [POS_W-1:0] o_out_z;
    logic [CHAN_W-1:0]       o_red;
    logic [CHAN_W-1:0]       o_green;
    logic [CHAN_W-1:0]       o_blue;
    logic [CHAN_W-1:0]       o_alpha;
    logic [WIDTH_W-1:0]      o_point_width;
    logic                    o_last;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    fading_trail_point_buffer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_elapsed     (i_elapsed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_point_valid (o_point_valid),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_point_width (o_point_width),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // register mirror
    logic               cfg_auto_add;
    logic [MAXP_W-1:0]  cfg_max_points;
    logic [AGE_W-1:0]   cfg_lifetime;
    logic [COLOR_W-1:0] cfg_color_start;
    logic [COLOR_W-1:0] cfg_color_end;
    logic [WIDTH_W-1:0] cfg_width_start;
    logic [WIDTH_W-1:0] cfg_width_end;

    // predicted trail, ring ordered oldest first from trail_head
    logic [POS_W-1:0] trail_x   [TRAIL_CAP];
    logic [POS_W-1:0] trail_y   [TRAIL_CAP];
    logic [POS_W-1:0] trail_z   [TRAIL_CAP];
    logic [AGE_W-1:0] trail_age [TRAIL_CAP];
    int               trail_head;
    int               trail_count;

    t_point expected_points[$];

    bit gaps_on;
    int errors;
    int frames_sent;
    int points_checked;
    int empty_seen;
    int deepest_trail;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("fading_trail_point_buffer_core test failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [WIDTH_W-1:0] mix(input logic [WIDTH_W-1:0] from_v,
                                               input logic [WIDTH_W-1:0] to_v,
                                               input logic [Q_W-1:0] t);
        longint unsigned acc;
        acc = from_v * (17'd65536 - t) + to_v * t;
        return acc[31:16];
    endfunction

    task automatic retire_oldest();
        if (trail_count > 0) begin
            trail_head = (trail_head + 1) % TRAIL_CAP;
            trail_count--;
        end
    endtask

    task automatic queue_point(input t_point p);
        expected_points.insert(expected_points.size(), p);
    endtask

    task automatic predict_frame(input t_frame f);
        int              keep;
        int              slot;
        logic [AGE_W:0]  grown;
        longint unsigned ratio;
        logic [Q_W-1:0]  t_q;
        t_point          p;
        if (cfg_auto_add) begin
            keep = (cfg_max_points > TRAIL_CAP) ? TRAIL_CAP : int'(cfg_max_points);
            // full ring: make room before the append
            if (trail_count >= TRAIL_CAP)
                retire_oldest();
            slot = (trail_head + trail_count) % TRAIL_CAP;
            trail_x[slot]   = f.x;
            trail_y[slot]   = f.y;
            trail_z[slot]   = f.z;
            trail_age[slot] = '0;
            trail_count++;
            while (trail_count > keep)
                retire_oldest();
        end
        if (trail_count > deepest_trail)
            deepest_trail = trail_count;
        // aging saturates instead of wrapping
        for (int i = 0; i < trail_count; i++) begin
            slot = (trail_head + i) % TRAIL_CAP;
            grown = {1'b0, trail_age[slot]} + {1'b0, f.elapsed};
            trail_age[slot] = grown[AGE_W] ? ftpb_pkg::AGE_MAX : grown[AGE_W-1:0];
        end
        // expired points always form a run at the oldest end
        while (trail_count > 0 && trail_age[trail_head] >= cfg_lifetime)
            retire_oldest();
        if (trail_count == 0) begin
            p = '0;
            p.last = 1'b1;
            queue_point(p);
        end else begin
            for (int i = 0; i < trail_count; i++) begin
                slot = (trail_head + i) % TRAIL_CAP;
                ratio = (longint'(trail_age[slot]) << 16) / cfg_lifetime;
                t_q = (ratio > 65535) ? 16'hFFFF : ratio[Q_W-1:0];
                p.live  = 1'b1;
                p.x     = trail_x[slot];
                p.y     = trail_y[slot];
                p.z     = trail_z[slot];
                p.red   = CHAN_W'(mix(WIDTH_W'(cfg_color_start[31:24]),
                                      WIDTH_W'(cfg_color_end[31:24]), t_q));
                p.green = CHAN_W'(mix(WIDTH_W'(cfg_color_start[23:16]),
                                      WIDTH_W'(cfg_color_end[23:16]), t_q));
                p.blue  = CHAN_W'(mix(WIDTH_W'(cfg_color_start[15:8]),
                                      WIDTH_W'(cfg_color_end[15:8]), t_q));
                p.alpha = CHAN_W'(mix(WIDTH_W'(cfg_color_start[7:0]),
                                      WIDTH_W'(cfg_color_end[7:0]), t_q));
                p.width = mix(cfg_width_start, cfg_width_end, t_q);
                p.last  = (i == trail_count - 1);
                queue_point(p);
            end
        end
    endtask

    // ---------------------------------------------------------------- checker

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // output side: check each accepted transaction, then pick next cycle's stall
    always @(posedge i_clk) begin : point_monitor
        t_point got;
        t_point want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_point_valid, o_out_x, o_out_y, o_out_z, o_red, o_green, o_blue,
                   o_alpha, o_point_width, o_last};
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected point transaction, expected none, actual %0h",
                         $time, got);
                errors++;
            end else begin
                want = expected_points.pop_front();
                check_field("point_valid", want.live, got.live);
                check_field("out_x", want.x, got.x);
                check_field("out_y", want.y, got.y);
                check_field("out_z", want.z, got.z);
                check_field("red", want.red, got.red);
                check_field("green", want.green, got.green);
                check_field("blue", want.blue, got.blue);
                check_field("alpha", want.alpha, got.alpha);
                check_field("point_width", want.width, got.width);
                check_field("last", want.last, got.last);
                if (want.live)
                    points_checked++;
                else
                    empty_seen++;
            end
        end
        i_out_stall <= gaps_on && ($urandom_range(99) < 27);
    end

    // ---------------------------------------------------------------- drivers

    // valid stays high after acceptance so back-to-back frames need no drop
    task automatic send_frame(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [POS_W-1:0] z, input logic [AGE_W-1:0] el);
        t_frame f;
        f.x = x;
        f.y = y;
        f.z = z;
        f.elapsed = el;
        if (gaps_on && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_pos_z    <= z;
        i_elapsed  <= el;
        do @(posedge i_clk); while (o_in_stall);
        predict_frame(f);
        frames_sent++;
    endtask

    task automatic send_random_frame(input logic [AGE_W-1:0] el);
        send_frame($urandom(), $urandom(), $urandom(), el);
    endtask

    // drop valid and wait until every predicted point has come out
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ftpb_pkg::CFG_AUTO_ADD:    cfg_auto_add    = data[0];
            ftpb_pkg::CFG_MAX_POINTS:  cfg_max_points  = data[MAXP_W-1:0];
            ftpb_pkg::CFG_LIFETIME:    cfg_lifetime    = data[AGE_W-1:0];
            ftpb_pkg::CFG_COLOR_START: cfg_color_start = data;
            ftpb_pkg::CFG_COLOR_END:   cfg_color_end   = data;
            ftpb_pkg::CFG_WIDTH_START: cfg_width_start = data[WIDTH_W-1:0];
            ftpb_pkg::CFG_WIDTH_END:   cfg_width_end   = data[WIDTH_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests

    // reset register values; last frame expires everything -> empty trail
    task automatic test_defaults();
        send_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd0);
        send_frame(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'd1);
        send_frame(32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_8000, 24'd500000);
        send_frame(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, ftpb_pkg::AGE_MAX);
        wait_drain();
    endtask

    // inverted color and width ramps, shortest and longest lifetime
    task automatic test_blend_extremes();
        write_reg(ftpb_pkg::CFG_LIFETIME, CFG_DATA_W'(ftpb_pkg::AGE_MAX));
        write_reg(ftpb_pkg::CFG_COLOR_START, 32'h0000_0000);
        write_reg(ftpb_pkg::CFG_COLOR_END, 32'hFFFF_FFFF);
        write_reg(ftpb_pkg::CFG_WIDTH_START, 32'h0000_0000);
        write_reg(ftpb_pkg::CFG_WIDTH_END, 32'h0000_FFFF);
        send_random_frame(24'd0);
        send_random_frame(24'h7F_FFFF);
        send_random_frame(24'h7F_FFFF);
        wait_drain();
        write_reg(ftpb_pkg::CFG_LIFETIME, 32'd1);
        write_reg(ftpb_pkg::CFG_COLOR_START, 32'h00FF_00FF);
        write_reg(ftpb_pkg::CFG_COLOR_END, 32'hFF00_FF00);
        send_random_frame(24'd0);
        wait_drain();
    endtask

    // an old point near the top of the age range must saturate, not wrap back alive
    task automatic test_age_saturation();
        write_reg(ftpb_pkg::CFG_LIFETIME, CFG_DATA_W'(ftpb_pkg::AGE_MAX));
        send_random_frame(24'hFF_FFF0);
        send_random_frame(24'h00_0020);
        wait_drain();
    endtask

    task automatic test_lifetime_zero();
        write_reg(ftpb_pkg::CFG_LIFETIME, 32'd0);
        send_random_frame(24'd0);
        send_random_frame(24'd3);
        wait_drain();
    endtask

    // max_points of zero, one and above the ring size
    task automatic test_trail_limits();
        write_reg(ftpb_pkg::CFG_LIFETIME, CFG_DATA_W'(ftpb_pkg::AGE_MAX));
        write_reg(ftpb_pkg::CFG_MAX_POINTS, 32'd0);
        send_random_frame(24'd10);
        wait_drain();
        write_reg(ftpb_pkg::CFG_MAX_POINTS, 32'd1);
        repeat (3) send_random_frame(24'd100);
        wait_drain();
        write_reg(ftpb_pkg::CFG_MAX_POINTS, 32'd127);
        repeat (3) send_random_frame(24'd1000);
        wait_drain();
    endtask

    // no append: frames only age the existing trail until it is gone
    task automatic test_auto_add_off();
        write_reg(ftpb_pkg::CFG_AUTO_ADD, 32'd0);
        send_random_frame(24'h10_0000);
        send_random_frame(24'h40_0000);
        send_random_frame(ftpb_pkg::AGE_MAX);
        wait_drain();
        write_reg(ftpb_pkg::CFG_AUTO_ADD, 32'd1);
    endtask

    // random register settings per phase; one phase pauses mid-way until drained
    task automatic test_random_trails(input int phases, input int per_phase);
        logic [AGE_W-1:0] life;
        int unsigned      span;
        int unsigned      pick;
        logic [AGE_W-1:0] el;
        for (int ph = 0; ph < phases; ph++) begin
            wait_drain();
            write_reg(ftpb_pkg::CFG_AUTO_ADD, CFG_DATA_W'($urandom_range(99) < 85));
            pick = $urandom_range(9);
            if (pick < 4)
                write_reg(ftpb_pkg::CFG_MAX_POINTS, $urandom_range(1, 16));
            else if (pick < 6)
                write_reg(ftpb_pkg::CFG_MAX_POINTS, $urandom_range(17, 64));
            else if (pick < 8)
                write_reg(ftpb_pkg::CFG_MAX_POINTS, $urandom_range(65, 127));
            else if (pick == 8)
                write_reg(ftpb_pkg::CFG_MAX_POINTS, 32'd0);
            else
                write_reg(ftpb_pkg::CFG_MAX_POINTS, 32'd64);
            case ($urandom_range(3))
                0: life = AGE_W'($urandom());
                1: life = AGE_W'($urandom_range(1, 4096));
                2: life = ftpb_pkg::AGE_MAX;
                default: life = AGE_W'($urandom_range(1000, 2000000));
            endcase
            write_reg(ftpb_pkg::CFG_LIFETIME, CFG_DATA_W'(life));
            write_reg(ftpb_pkg::CFG_COLOR_START, $urandom());
            write_reg(ftpb_pkg::CFG_COLOR_END, $urandom());
            write_reg(ftpb_pkg::CFG_WIDTH_START, $urandom_range(0, 65535));
            write_reg(ftpb_pkg::CFG_WIDTH_END, $urandom_range(0, 65535));
            // span ~ number of frames a point survives
            span = $urandom_range(1, 70);
            for (int n = 0; n < per_phase; n++) begin
                if (ph == 2 && n == per_phase / 2)
                    wait_drain();
                pick = $urandom_range(9);
                if (pick < 8)
                    el = AGE_W'($urandom_range(0, life / span));
                else if (pick == 8)
                    el = AGE_W'($urandom());
                else
                    el = '0;
                send_random_frame(el);
            end
        end
        wait_drain();
    endtask

    // back-to-back frames with no idling on either side; fills the ring past capacity
    task automatic test_steady_stream();
        gaps_on = 1'b0;
        write_reg(ftpb_pkg::CFG_AUTO_ADD, 32'd1);
        write_reg(ftpb_pkg::CFG_MAX_POINTS, 32'd127);
        write_reg(ftpb_pkg::CFG_LIFETIME, CFG_DATA_W'(ftpb_pkg::AGE_MAX));
        write_reg(ftpb_pkg::CFG_COLOR_START, $urandom());
        write_reg(ftpb_pkg::CFG_COLOR_END, $urandom());
        write_reg(ftpb_pkg::CFG_WIDTH_START, $urandom_range(0, 65535));
        write_reg(ftpb_pkg::CFG_WIDTH_END, $urandom_range(0, 65535));
        repeat (75) send_random_frame(AGE_W'($urandom_range(0, 24'h3_FFFF)));
        wait_drain();
        gaps_on = 1'b1;
    endtask

    // build a short trail, then stop appending and let it fade out
    task automatic test_frozen_trail();
        write_reg(ftpb_pkg::CFG_MAX_POINTS, 32'd64);
        write_reg(ftpb_pkg::CFG_LIFETIME, 32'h0010_0000);
        repeat (10) send_random_frame(AGE_W'($urandom_range(0, 24'h1000)));
        wait_drain();
        write_reg(ftpb_pkg::CFG_AUTO_ADD, 32'd0);
        repeat (10) send_random_frame(AGE_W'($urandom_range(24'h1_0000, 24'h3_0000)));
        wait_drain();
        write_reg(ftpb_pkg::CFG_AUTO_ADD, 32'd1);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pos_z     <= '0;
        i_elapsed   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= ftpb_pkg::CFG_AUTO_ADD;
        i_cfg_data  <= '0;
        cfg_auto_add    = ftpb_pkg::RST_AUTO_ADD;
        cfg_max_points  = ftpb_pkg::RST_MAX_POINTS;
        cfg_lifetime    = ftpb_pkg::RST_LIFETIME;
        cfg_color_start = ftpb_pkg::RST_COLOR_START;
        cfg_color_end   = ftpb_pkg::RST_COLOR_END;
        cfg_width_start = ftpb_pkg::RST_WIDTH_START;
        cfg_width_end   = ftpb_pkg::RST_WIDTH_END;
        trail_head     = 0;
        trail_count    = 0;
        gaps_on        = 1'b1;
        errors         = 0;
        frames_sent    = 0;
        points_checked = 0;
        empty_seen     = 0;
        deepest_trail  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_blend_extremes();
        test_age_saturation();
        test_lifetime_zero();
        test_trail_limits();
        test_auto_add_off();
        test_random_trails(6, 42);
        test_steady_stream();
        test_frozen_trail();

        wait_drain();
        repeat (16) @(posedge i_clk);
        $display("Covered %0d frames: %0d trail points and %0d empty-trail transactions checked,",
                 frames_sent, points_checked, empty_seen);
        $display("trail depth reached %0d points, %0d mismatches.", deepest_trail, errors);
        if (errors == 0)
            $display("fading_trail_point_buffer_core test passed");
        else
            $display("fading_trail_point_buffer_core test failed");
        $finish;
    end

endmodule
